// ===== src/ordvd_pkg.sv =====
// Package for the overlap record delta varint decoder.
// Holds the word and record types, the flag bit positions and the record length clamp.
// Has no dependencies.
package ordvd_pkg;

  localparam int unsigned StoreDepth = 10;
  localparam int unsigned IdxW       = 4;

  localparam logic [IdxW-1:0] FieldsMin   = 4'd8;
  localparam logic [IdxW-1:0] FieldsMax   = 4'd10;
  localparam logic [IdxW-1:0] FieldsReset = 4'd8;
  localparam logic [IdxW-1:0] LastIdx     = 4'd9;
  localparam logic [IdxW-1:0] NineFields  = 4'd9;

  localparam int unsigned ContBit       = 7;
  localparam int unsigned FlagStrandBit = 0;
  localparam int unsigned FlagQrevBit   = 1;
  localparam int unsigned FlagTrevBit   = 2;
  localparam int unsigned FlagTaddBit   = 3;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t query_id;
    logic  strand;
    word_t query_start;
    word_t query_end;
    word_t target_id;
    word_t target_start;
    word_t target_end;
    word_t extra_seven;
    word_t extra_eight;
    word_t extra_nine;
  } record_t;

  // Clamp the programmed record length into the supported range.
  function automatic logic [IdxW-1:0] eff_fields(logic [IdxW-1:0] raw);
    logic [IdxW-1:0] res;
    if (raw < FieldsMin) begin
      res = FieldsMin;
    end else if (raw > FieldsMax) begin
      res = FieldsMax;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// ===== src/ordvd_record_calc.sv =====
// Record assembly for the overlap record delta varint decoder.
// Restores ids from deltas and derives the end coordinates; uses ordvd_pkg.
module ordvd_record_calc (
  input  ordvd_pkg::word_t                  fields_i [ordvd_pkg::StoreDepth],
  input  logic [ordvd_pkg::IdxW-1:0]        count_i,
  input  ordvd_pkg::word_t                  prev_qid_i,
  input  ordvd_pkg::word_t                  prev_tid_i,
  output ordvd_pkg::record_t                rec_o
);
  import ordvd_pkg::*;

  word_t flags;
  word_t tsum;

  assign flags = fields_i[1];
  assign tsum  = fields_i[5] + fields_i[3];

  always_comb begin
    rec_o.query_id     = flags[FlagQrevBit] ? (prev_qid_i - fields_i[0])
                                            : (prev_qid_i + fields_i[0]);
    rec_o.strand       = flags[FlagStrandBit];
    rec_o.query_start  = fields_i[2];
    rec_o.query_end    = fields_i[2] + fields_i[3];
    rec_o.target_id    = flags[FlagTrevBit] ? (prev_tid_i - fields_i[4])
                                            : (prev_tid_i + fields_i[4]);
    rec_o.target_start = fields_i[5];
    // difference sign comes from flag bit 3: set adds, clear subtracts
    rec_o.target_end   = flags[FlagTaddBit] ? (tsum + fields_i[6]) : (tsum - fields_i[6]);
    rec_o.extra_seven  = fields_i[7];
    rec_o.extra_eight  = (count_i >= NineFields) ? fields_i[8] : '0;
    rec_o.extra_nine   = (count_i >= FieldsMax) ? fields_i[9] : '0;
  end

endmodule

// ===== src/overlap_record_delta_varint_decoder.sv =====
// Overlap record delta varint decoder: input byte register, varint and field state, result register.
// A record passes from the input byte register to the result register once its final byte advances.
// Throughput: one byte per cycle; the input stalls only when a record completes while the
// previous record still sits unclaimed in the result register.
// Reset clears the handshake, accumulator, field index, previous ids and record length (8);
// the field store is not cleared and holds whatever the current record has written.
module overlap_record_delta_varint_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ordvd_pkg::IdxW-1:0] record_fields_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 code_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [31:0]                query_id_o,
  output logic                       strand_o,
  output logic [31:0]                query_start_o,
  output logic [31:0]                query_end_o,
  output logic [31:0]                target_id_o,
  output logic [31:0]                target_start_o,
  output logic [31:0]                target_end_o,
  output logic [31:0]                extra_seven_o,
  output logic [31:0]                extra_eight_o,
  output logic [31:0]                extra_nine_o
);
  import ordvd_pkg::*;

  logic              byte_vld_q;
  logic [7:0]        byte_q;
  logic [IdxW-1:0]   rf_q;
  word_t             acc_q;
  logic [IdxW-1:0]   idx_q;
  word_t             store_q [StoreDepth];
  word_t             prev_qid_q;
  word_t             prev_tid_q;
  logic              out_valid_q;
  record_t           rec_q;

  word_t             acc_d;
  logic [IdxW-1:0]   idx_c;
  logic [IdxW-1:0]   count;
  logic              last_byte;
  logic              rec_end;
  logic              stall;
  logic              advance;
  word_t             fields_view [StoreDepth];
  record_t           rec;

  assign cfg_ready_o = 1'b1;

  assign count     = eff_fields(rf_q);
  assign acc_d     = {acc_q[24:0], byte_q[6:0]};
  assign last_byte = byte_vld_q && !byte_q[ContBit];
  assign idx_c     = (idx_q > LastIdx) ? LastIdx : idx_q;
  assign rec_end   = last_byte && ((idx_c + 4'd1) >= count);
  assign stall     = rec_end && out_valid_q && !out_ready_i;
  assign advance   = byte_vld_q && !stall;
  assign in_ready_o = !byte_vld_q || !stall;

  // Present the completing value alongside the stored ones.
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      fields_view[i] = (last_byte && (idx_c == IdxW'(i))) ? acc_d : store_q[i];
    end
  end

  ordvd_record_calc u_calc (
    .fields_i   (fields_view),
    .count_i    (count),
    .prev_qid_i (prev_qid_q),
    .prev_tid_i (prev_tid_q),
    .rec_o      (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= FieldsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rf_q <= record_fields_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= code_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      idx_q      <= '0;
      prev_qid_q <= '0;
      prev_tid_q <= '0;
    end else if (advance) begin
      acc_q <= byte_q[ContBit] ? acc_d : '0;
      if (last_byte) begin
        idx_q <= rec_end ? '0 : (idx_c + 4'd1);
      end
      if (rec_end) begin
        prev_qid_q <= rec.query_id;
        prev_tid_q <= rec.target_id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_byte) begin
      store_q[idx_c] <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && rec_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rec_end) begin
      rec_q <= rec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign query_id_o     = rec_q.query_id;
  assign strand_o       = rec_q.strand;
  assign query_start_o  = rec_q.query_start;
  assign query_end_o    = rec_q.query_end;
  assign target_id_o    = rec_q.target_id;
  assign target_start_o = rec_q.target_start;
  assign target_end_o   = rec_q.target_end;
  assign extra_seven_o  = rec_q.extra_seven;
  assign extra_eight_o  = rec_q.extra_eight;
  assign extra_nine_o   = rec_q.extra_nine;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("field index past last store entry");

  a_idx_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rec_end |=> idx_q == '0 && acc_q == '0)
    else $error("record end did not restart field index and accumulator");

  a_short_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && rec_end && count == FieldsMin |=>
      rec_q.extra_eight == '0 && rec_q.extra_nine == '0)
    else $error("basic record carries extended values");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without a held result");

endmodule
